// ----- rtl/cfc_pkg.sv -----
// shared types, constants and the crc-32c byte update for the frame checker
// no dependencies
`timescale 1ns / 1ps

package cfc_pkg;

	localparam int MAGIC_BYTES = 4;
	localparam int POS_W = 34;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam logic [POS_W-1:0] MAGIC_END = POS_W'(MAGIC_BYTES);
	localparam logic [POS_W-1:0] VERSION_END = POS_W'(MAGIC_BYTES + 4);
	localparam logic [POS_W-1:0] HDR_LEN = POS_W'(MAGIC_BYTES + 8);
	localparam logic [POS_W-1:0] MIN_LEN = POS_W'(MAGIC_BYTES + 12);
	localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

	localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_WORD = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_VERSION = 1'b1;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_SMALL   = 3'd1,
		ST_MAGIC   = 3'd2,
		ST_VERSION = 3'd3,
		ST_SIZE    = 3'd4,
		ST_CRC     = 3'd5
	} status_t;

	// one classified byte, front to back
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       magic_miss;
		logic       ver_en;
		logic       len_en;
		logic       crc_en;
		logic       too_small;
		logic       size_ok;
	} entry_t;

	function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ----- rtl/cfc_front.sv -----
// front end: counts bytes, tracks the declared length and classifies each byte
// depends on cfc_pkg
`timescale 1ns / 1ps

module cfc_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [7:0]         file_byte,
	input  logic               last_byte,
	input  logic [63:0]        magic_word,
	output cfc_pkg::entry_t    entry
);
	import cfc_pkg::*;

	logic [POS_W-1:0] pos_q;
	logic [31:0]      length_q;
	logic [7:0][7:0]  magic_bytes;
	logic             in_magic;
	logic             in_version;
	logic             in_length;
	logic [31:0]      length_next;
	logic [POS_W-1:0] total;

	assign magic_bytes = magic_word;
	assign in_magic = pos_q < MAGIC_END;
	assign in_version = !in_magic && (pos_q < VERSION_END);
	assign in_length = !in_magic && !in_version && (pos_q < HDR_LEN);
	assign length_next = in_length ? {file_byte, length_q[31:8]} : length_q;
	assign total = (pos_q == POS_MAX) ? pos_q : pos_q + POS_W'(1);

	always_comb begin
		entry.data = file_byte;
		entry.last = last_byte;
		entry.magic_miss = in_magic && (magic_bytes[pos_q[2:0]] != file_byte);
		entry.ver_en = in_version;
		entry.len_en = in_length;
		entry.crc_en = (pos_q < HDR_LEN) || (pos_q < HDR_LEN + {2'b00, length_q});
		entry.too_small = total < MIN_LEN;
		entry.size_ok = total == (MIN_LEN + {2'b00, length_next});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			length_q <= '0;
		end else if (accept) begin
			if (last_byte) begin
				pos_q <= '0;
				length_q <= '0;
			end else begin
				pos_q <= total;
				length_q <= length_next;
			end
		end
	end

`ifndef SYNTHESIS
	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last_byte |=> pos_q == '0 && length_q == '0)
		else $error("byte position not cleared after final byte");
`endif

endmodule

// ----- rtl/cfc_fifo.sv -----
// short queue of classified bytes between front and back
// depends on cfc_pkg
`timescale 1ns / 1ps

module cfc_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  cfc_pkg::entry_t push_data,
	input  logic            pop,
	output cfc_pkg::entry_t pop_data,
	output logic            empty,
	output logic            full
);
	import cfc_pkg::*;

	entry_t                mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;

	assign empty = count_q == '0;
	assign full = count_q == FIFO_CNT_W'(FIFO_DEPTH);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
					: wr_ptr_q + FIFO_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
					: rd_ptr_q + FIFO_PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + FIFO_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - FIFO_CNT_W'(1);
			end
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FIFO_CNT_W'(FIFO_DEPTH))
		else $error("queue count beyond depth");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");
`endif

endmodule

// ----- rtl/cfc_back.sv -----
// back end: crc, header fields, trailer capture and final status register
// depends on cfc_pkg
`timescale 1ns / 1ps

module cfc_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            fifo_empty,
	input  cfc_pkg::entry_t entry,
	output logic            pop,
	input  logic [31:0]     max_version,
	output logic            result_valid,
	input  logic            result_stall,
	output logic [2:0]      status,
	output logic [31:0]     frame_version,
	output logic [31:0]     payload_length,
	output logic [31:0]     computed_crc
);
	import cfc_pkg::*;

	logic [31:0] crc_q;
	logic        magic_bad_q;
	logic [31:0] version_q;
	logic [31:0] length_q;
	logic [31:0] trailer_q;
	logic        res_valid_q;
	status_t     status_q;
	logic [31:0] version_out_q;
	logic [31:0] length_out_q;
	logic [31:0] crc_out_q;

	logic [31:0] crc_n;
	logic        magic_bad_n;
	logic [31:0] version_n;
	logic [31:0] length_n;
	logic [31:0] trailer_n;
	status_t     status_n;

	assign pop = !fifo_empty && (!res_valid_q || !result_stall);

	always_comb begin
		crc_n = entry.crc_en ? crc32c_byte(crc_q, entry.data) : crc_q;
		trailer_n = entry.crc_en ? trailer_q : {entry.data, trailer_q[31:8]};
		magic_bad_n = magic_bad_q || entry.magic_miss;
		version_n = entry.ver_en ? {entry.data, version_q[31:8]} : version_q;
		length_n = entry.len_en ? {entry.data, length_q[31:8]} : length_q;
		priority if (entry.too_small) begin
			status_n = ST_SMALL;
		end else if (magic_bad_n) begin
			status_n = ST_MAGIC;
		end else if (version_n > max_version) begin
			status_n = ST_VERSION;
		end else if (!entry.size_ok) begin
			status_n = ST_SIZE;
		end else if (trailer_n != ~crc_n) begin
			status_n = ST_CRC;
		end else begin
			status_n = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_INIT;
			magic_bad_q <= 1'b0;
			version_q <= '0;
			length_q <= '0;
			trailer_q <= '0;
		end else if (pop) begin
			if (entry.last) begin
				crc_q <= CRC_INIT;
				magic_bad_q <= 1'b0;
				version_q <= '0;
				length_q <= '0;
				trailer_q <= '0;
			end else begin
				crc_q <= crc_n;
				magic_bad_q <= magic_bad_n;
				version_q <= version_n;
				length_q <= length_n;
				trailer_q <= trailer_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (pop) begin
			res_valid_q <= entry.last;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && entry.last) begin
			status_q <= status_n;
			version_out_q <= version_n;
			length_out_q <= length_n;
			crc_out_q <= ~crc_n;
		end
	end

	assign result_valid = res_valid_q;
	assign status = status_q;
	assign frame_version = version_out_q;
	assign payload_length = length_out_q;
	assign computed_crc = crc_out_q;

`ifndef SYNTHESIS
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> status_q == ST_OK || status_q == ST_SMALL || status_q == ST_MAGIC
			|| status_q == ST_VERSION || status_q == ST_SIZE || status_q == ST_CRC)
		else $error("result status out of range");
`endif

endmodule

// ----- rtl/crc32c_frame_checker_core.sv -----
// top level of the crc-32c frame checker: config registers, front, queue, back
// depends on cfc_pkg, cfc_front, cfc_fifo, cfc_back
`timescale 1ns / 1ps

// usage:
// byte channel: file_byte and last_byte with byte_valid; a transaction happens
//   at a clock edge with byte_valid high and byte_stall low. last_byte marks the
//   final byte of a file; the next byte starts a new file.
// result channel: one transaction per file, with status, frame_version,
//   payload_length and computed_crc, under result_valid and result_stall.
// config channel: cfg_index 0 is magic_word, 1 is max_version; writes complete
//   when cfg_valid and cfg_ready are high (cfg_ready is always high). write only
//   while no file is in flight.
// throughput: one byte per cycle while byte_stall is low; the crc update of one byte
//   and the position compares are each combinational.
// final byte: it enters the four-entry queue at its transaction; the back end loads
//   the result register and raises result_valid when it pops that byte.
// reset: arst_n clears the queue, frame state and result_valid, and loads magic_word
//   with 0 and max_version with 1.
// receiver stall: the result register holds, the back end stops, the queue
//   fills and byte_stall rises once it holds four bytes.

module crc32c_frame_checker_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      byte_valid,
	output logic                      byte_stall,
	input  logic [7:0]                file_byte,
	input  logic                      last_byte,
	output logic                      result_valid,
	input  logic                      result_stall,
	output logic [2:0]                status,
	output logic [31:0]               frame_version,
	output logic [31:0]               payload_length,
	output logic [31:0]               computed_crc,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [cfc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]               cfg_data
);
	import cfc_pkg::*;

	logic [63:0] magic_word_q;
	logic [31:0] max_version_q;
	logic        accept;
	logic        fifo_full;
	logic        fifo_empty;
	logic        pop;
	entry_t      push_entry;
	entry_t      pop_entry;

	assign cfg_ready = 1'b1;
	assign byte_stall = fifo_full;
	assign accept = byte_valid && !fifo_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_word_q <= '0;
			max_version_q <= 32'd1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MAGIC_WORD: magic_word_q <= cfg_data;
				CFG_MAX_VERSION: max_version_q <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	cfc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.file_byte  (file_byte),
		.last_byte  (last_byte),
		.magic_word (magic_word_q),
		.entry      (push_entry)
	);

	cfc_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (push_entry),
		.pop       (pop),
		.pop_data  (pop_entry),
		.empty     (fifo_empty),
		.full      (fifo_full)
	);

	cfc_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.fifo_empty     (fifo_empty),
		.entry          (pop_entry),
		.pop            (pop),
		.max_version    (max_version_q),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.status         (status),
		.frame_version  (frame_version),
		.payload_length (payload_length),
		.computed_crc   (computed_crc)
	);

endmodule
